// ----- src/dna_motif_window_scorer_unit_macros.svh -----
// assertion macros shared by the motif window scorer rtl
// no dependencies; included by the modules that carry concurrent checks
`ifndef DNA_MOTIF_WINDOW_SCORER_UNIT_MACROS_SVH
`define DNA_MOTIF_WINDOW_SCORER_UNIT_MACROS_SVH

// same-cycle implication, checks off while reset is low
`define DMWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checks off while reset is low
`define DMWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dmws_pkg.sv -----
// shared types and constants of the motif window scorer
// no dependencies; imported by the interfaces and every module
package dmws_pkg;

	localparam int POS_W      = 4;
	localparam int BASE_W     = 2;
	localparam int NUM_BASES  = 4;
	localparam int MASK_W     = 16;
	localparam int SCORE_W    = 23;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// item kinds on the sequence channel
	localparam logic FUNC_WEIGHT = 1'b0;
	localparam logic FUNC_BASE   = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVCOMP_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VITERBI_MODE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE    = 2'd3;

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd8;

	localparam logic signed [MASK_W-1:0] MASK_NEG_INF = 16'sh8000;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX        = 23'sd4194303;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN_FINITE = -23'sd4194303;
	localparam logic signed [SCORE_W-1:0] SCORE_NEG_INF    = 23'sh400000;

	typedef struct packed {
		logic [LEN_W-1:0] motif_length;
		logic             revcomp_enable;
		logic             viterbi_mode;
		logic             mask_enable;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic score_valid;
	} pipe_ctrl_t;

endpackage

// ----- src/dmws_in_if.sv -----
// sequence channel: weight writes and sequence bases
// depends on dmws_pkg
interface dmws_in_if import dmws_pkg::*; #(
	parameter int WEIGHT_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic                          first_of_sequence;
	logic [POS_W-1:0]              motif_position;
	logic [BASE_W-1:0]             base;
	logic signed [WEIGHT_BITS-1:0] weight_value;
	logic signed [MASK_W-1:0]      mask_score;

	modport source (
		output valid, func, first_of_sequence, motif_position, base, weight_value,
		output mask_score,
		input  ready
	);
	modport sink (
		input  valid, func, first_of_sequence, motif_position, base, weight_value,
		input  mask_score,
		output ready
	);
endinterface

// ----- src/dmws_out_if.sv -----
// result channel: one window score per sequence base
// depends on dmws_pkg
interface dmws_out_if import dmws_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] window_score;
	logic                      score_valid;
	logic                      minus_infinity;

	modport source (output valid, window_score, score_valid, minus_infinity, input ready);
	modport sink (input valid, window_score, score_valid, minus_infinity, output ready);
endinterface

// ----- src/dmws_cfg_if.sv -----
// register write channel
// depends on dmws_pkg
interface dmws_cfg_if import dmws_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/dmws_pos_cell.sv -----
// one motif position: its four weights and the first-stage lookups
// depends on dmws_pkg
module dmws_pos_cell import dmws_pkg::*; #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [BASE_W-1:0]             wr_base,
	input  logic signed [WEIGHT_BITS-1:0] wr_data,
	input  logic                          ld_s1,
	input  logic [BASE_W-1:0]             fwd_base,
	input  logic [BASE_W-1:0]             rev_base,
	input  logic                          fwd_use,
	input  logic                          rev_use,
	output logic signed [WEIGHT_BITS-1:0] fwd_term_s1,
	output logic                          fwd_inf_s1,
	output logic signed [WEIGHT_BITS-1:0] rev_term_s1,
	output logic                          rev_inf_s1
);
	localparam logic signed [WEIGHT_BITS-1:0] W_NEG_INF = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	logic signed [WEIGHT_BITS-1:0] weight_q [NUM_BASES];
	logic signed [WEIGHT_BITS-1:0] fwd_w;
	logic signed [WEIGHT_BITS-1:0] rev_w;
	logic                          fwd_ninf;
	logic                          rev_ninf;

	// reverse strand reads the complemented base
	assign fwd_w    = weight_q[fwd_base];
	assign rev_w    = weight_q[~rev_base];
	assign fwd_ninf = (fwd_w == W_NEG_INF);
	assign rev_ninf = (rev_w == W_NEG_INF);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			weight_q[wr_base] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			fwd_inf_s1  <= fwd_use && fwd_ninf;
			fwd_term_s1 <= (fwd_use && !fwd_ninf) ? fwd_w : '0;
			rev_inf_s1  <= rev_use && rev_ninf;
			rev_term_s1 <= (rev_use && !rev_ninf) ? rev_w : '0;
		end
	end

endmodule

// ----- src/dmws_sum.sv -----
// adder tree, strand combine, saturation and the result register
// depends on dmws_pkg, dmws_out_if and the assertion macro header
`include "dna_motif_window_scorer_unit_macros.svh"
module dmws_sum import dmws_pkg::*; #(
	parameter int MAX_MOTIF_LEN = 16,
	parameter int WEIGHT_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg_q,
	input  pipe_ctrl_t                    ctl_s1,
	input  logic signed [WEIGHT_BITS-1:0] fwd_term_s1 [MAX_MOTIF_LEN],
	input  logic signed [WEIGHT_BITS-1:0] rev_term_s1 [MAX_MOTIF_LEN],
	input  logic signed [MASK_W-1:0]      mask_term_s1 [MAX_MOTIF_LEN],
	input  logic [MAX_MOTIF_LEN-1:0]      fwd_inf_s1,
	input  logic [MAX_MOTIF_LEN-1:0]      rev_inf_s1,
	input  logic [MAX_MOTIF_LEN-1:0]      mask_inf_s1,
	output logic                          rdy_s2,
	dmws_out_if.source                    score_out
);
	localparam int GRP    = 4;
	localparam int NGRP   = (MAX_MOTIF_LEN + GRP - 1) / GRP;
	localparam int NPAD   = NGRP * GRP;
	localparam int TERM_W = (WEIGHT_BITS > MASK_W) ? WEIGHT_BITS : MASK_W;
	localparam int RAW_W  = TERM_W + $clog2(MAX_MOTIF_LEN + 1) + 3;
	localparam int TOT_W  = (RAW_W > SCORE_W + 1) ? RAW_W : SCORE_W + 1;

	localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(SCORE_MAX);
	localparam logic signed [TOT_W-1:0] SAT_LO = TOT_W'(SCORE_MIN_FINITE);

	logic signed [TOT_W-1:0] fpad [NPAD];
	logic signed [TOT_W-1:0] rpad [NPAD];
	logic signed [TOT_W-1:0] mpad [NPAD];
	logic [NPAD-1:0]         finf_pad;
	logic [NPAD-1:0]         rinf_pad;
	logic [NPAD-1:0]         minf_pad;

	logic signed [TOT_W-1:0] fsum_c [NGRP];
	logic signed [TOT_W-1:0] rsum_c [NGRP];
	logic signed [TOT_W-1:0] msum_c [NGRP];
	logic [NGRP-1:0]         finf_c;
	logic [NGRP-1:0]         rinf_c;
	logic [NGRP-1:0]         minf_c;

	pipe_ctrl_t              ctl_s2;
	logic signed [TOT_W-1:0] fsum_s2 [NGRP];
	logic signed [TOT_W-1:0] rsum_s2 [NGRP];
	logic signed [TOT_W-1:0] msum_s2 [NGRP];
	logic [NGRP-1:0]         finf_s2;
	logic [NGRP-1:0]         rinf_s2;
	logic [NGRP-1:0]         minf_s2;

	logic signed [TOT_W-1:0] ftot_c;
	logic signed [TOT_W-1:0] rtot_c;
	logic signed [TOT_W-1:0] mtot_c;

	pipe_ctrl_t              ctl_s3;
	logic signed [TOT_W-1:0] ftot_s3;
	logic signed [TOT_W-1:0] rtot_s3;
	logic signed [TOT_W-1:0] mtot_s3;
	logic                    finf_s3;
	logic                    rinf_s3;
	logic                    minf_s3;
	logic                    rdy_s3;

	logic signed [TOT_W-1:0] sc_c;
	logic                    ok_c;
	logic signed [SCORE_W-1:0] score_c;
	logic                    minf_out_c;

	logic                      valid_s4;
	logic signed [SCORE_W-1:0] score_s4;
	logic                      sv_s4;
	logic                      minf_s4;
	logic                      rdy_s4;

	// pad the term row up to whole groups of four
	for (genvar i = 0; i < NPAD; i++) begin : g_pad
		if (i < MAX_MOTIF_LEN) begin : g_live
			assign fpad[i]     = TOT_W'(fwd_term_s1[i]);
			assign rpad[i]     = TOT_W'(rev_term_s1[i]);
			assign mpad[i]     = TOT_W'(mask_term_s1[i]);
			assign finf_pad[i] = fwd_inf_s1[i];
			assign rinf_pad[i] = rev_inf_s1[i];
			assign minf_pad[i] = mask_inf_s1[i];
		end else begin : g_zero
			assign fpad[i]     = '0;
			assign rpad[i]     = '0;
			assign mpad[i]     = '0;
			assign finf_pad[i] = 1'b0;
			assign rinf_pad[i] = 1'b0;
			assign minf_pad[i] = 1'b0;
		end
	end

	assign rdy_s4 = !valid_s4 || score_out.ready;
	assign rdy_s3 = !ctl_s3.valid || rdy_s4;
	assign rdy_s2 = !ctl_s2.valid || rdy_s3;

	// stage 2: group sums
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			fsum_c[g] = '0;
			rsum_c[g] = '0;
			msum_c[g] = '0;
			finf_c[g] = 1'b0;
			rinf_c[g] = 1'b0;
			minf_c[g] = 1'b0;
			for (int k = 0; k < GRP; k++) begin
				fsum_c[g] = fsum_c[g] + fpad[g*GRP+k];
				rsum_c[g] = rsum_c[g] + rpad[g*GRP+k];
				msum_c[g] = msum_c[g] + mpad[g*GRP+k];
				finf_c[g] = finf_c[g] | finf_pad[g*GRP+k];
				rinf_c[g] = rinf_c[g] | rinf_pad[g*GRP+k];
				minf_c[g] = minf_c[g] | minf_pad[g*GRP+k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (rdy_s2) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && ctl_s1.valid) begin
			fsum_s2 <= fsum_c;
			rsum_s2 <= rsum_c;
			msum_s2 <= msum_c;
			finf_s2 <= finf_c;
			rinf_s2 <= rinf_c;
			minf_s2 <= minf_c;
		end
	end

	// stage 3: strand and mask totals
	always_comb begin
		ftot_c = '0;
		rtot_c = '0;
		mtot_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			ftot_c = ftot_c + fsum_s2[g];
			rtot_c = rtot_c + rsum_s2[g];
			mtot_c = mtot_c + msum_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (rdy_s3) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && ctl_s2.valid) begin
			ftot_s3 <= ftot_c;
			rtot_s3 <= rtot_c;
			mtot_s3 <= mtot_c;
			finf_s3 <= |finf_s2;
			rinf_s3 <= |rinf_s2;
			minf_s3 <= |minf_s2;
		end
	end

	// stage 4: combine the strands, add the mask, saturate
	always_comb begin
		ok_c = !finf_s3;
		sc_c = ftot_s3;
		if (cfg_q.revcomp_enable) begin
			if (cfg_q.viterbi_mode) begin
				if (finf_s3 && rinf_s3) begin
					ok_c = 1'b0;
				end else if (finf_s3) begin
					ok_c = 1'b1;
					sc_c = rtot_s3;
				end else if (!rinf_s3 && (rtot_s3 > ftot_s3)) begin
					sc_c = rtot_s3;
				end
			end else begin
				ok_c = !finf_s3 && !rinf_s3;
				sc_c = ftot_s3 + rtot_s3;
			end
		end
		sc_c = sc_c + mtot_s3;
		if (minf_s3) begin
			ok_c = 1'b0;
		end
		if (!ctl_s3.score_valid) begin
			score_c    = '0;
			minf_out_c = 1'b0;
		end else if (!ok_c) begin
			score_c    = SCORE_NEG_INF;
			minf_out_c = 1'b1;
		end else if (sc_c > SAT_HI) begin
			score_c    = SCORE_MAX;
			minf_out_c = 1'b0;
		end else if (sc_c < SAT_LO) begin
			score_c    = SCORE_MIN_FINITE;
			minf_out_c = 1'b0;
		end else begin
			score_c    = sc_c[SCORE_W-1:0];
			minf_out_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && ctl_s3.valid) begin
			score_s4 <= score_c;
			sv_s4    <= ctl_s3.score_valid;
			minf_s4  <= minf_out_c;
		end
	end

	assign score_out.valid          = valid_s4;
	assign score_out.window_score   = score_s4;
	assign score_out.score_valid    = sv_s4;
	assign score_out.minus_infinity = minf_s4;

	`DMWS_ASSERT_NOW(a_neg_inf_code, clk, arst_n, valid_s4 && minf_s4, (score_s4 == SCORE_NEG_INF) && sv_s4, "minus infinity without its score code")
	`DMWS_ASSERT_NOW(a_unfilled_zero, clk, arst_n, valid_s4 && !sv_s4, (score_s4 == '0) && !minf_s4, "unfilled window carries a score")
	`DMWS_ASSERT_NEXT(a_s3_to_out, clk, arst_n, ctl_s3.valid && rdy_s4, valid_s4, "stage three result lost on its way out")

endmodule

// ----- src/dna_motif_window_scorer_unit.sv -----
// Position weight matrix scanner over a stream of DNA bases.
// Channels: cfg writes a register (index 0 motif length, 1 reverse strand, 2 max
// combine, 3 mask add); seq_in carries weight writes (func 0) and bases (func 1);
// score_out returns one transaction per base, none per weight write.
// A weight write takes effect for every base accepted after it.
// A base goes to score_out through lookup, group sums, strand totals, and combine
// and saturate. Throughput: one base per cycle while seq_in holds ready; weight
// writes also go at one per cycle. The user must keep window length, strand and
// mask settings static while bases are in flight; the block does not enforce it.
// Reset clears the registers to length 8 with all modes off, empties the pipeline
// and the window fill count; weights are undefined until written.
// When score_out stalls, each stage keeps taking transactions until it is full,
// so seq_in stays ready for up to four more bases before it drops ready.
// depends on dmws_pkg, the three channel interfaces, dmws_pos_cell and dmws_sum
`include "dna_motif_window_scorer_unit_macros.svh"
module dna_motif_window_scorer_unit import dmws_pkg::*; #(
	parameter int MAX_MOTIF_LEN = 16,
	parameter int WEIGHT_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	dmws_cfg_if.sink   cfg,
	dmws_in_if.sink    seq_in,
	dmws_out_if.source score_out
);
	localparam int CNT_W     = $clog2(MAX_MOTIF_LEN + 1);
	localparam int HIST_BITS = BASE_W * MAX_MOTIF_LEN;
	localparam int SH_W      = $clog2(HIST_BITS + 1);

	cfg_t                     cfg_q;
	logic [CNT_W-1:0]         len_c;
	logic [CNT_W-1:0]         fill_q;
	logic [CNT_W-1:0]         fill_b;
	logic [CNT_W-1:0]         fill_n;
	logic                     sv_c;
	logic                     base_acc;
	logic                     wr_acc;
	logic                     rdy_s1;
	logic                     rdy_s2;

	logic [BASE_W-1:0]        hist_q [MAX_MOTIF_LEN];
	logic [BASE_W-1:0]        hist_n [MAX_MOTIF_LEN];
	logic signed [MASK_W-1:0] mask_q [MAX_MOTIF_LEN];
	logic signed [MASK_W-1:0] mask_n [MAX_MOTIF_LEN];
	logic [HIST_BITS-1:0]     rv_c;
	logic [HIST_BITS-1:0]     sh_c;
	logic [SH_W-1:0]          shamt_c;

	pipe_ctrl_t                    ctl_s1;
	logic signed [WEIGHT_BITS-1:0] fwd_term_s1 [MAX_MOTIF_LEN];
	logic signed [WEIGHT_BITS-1:0] rev_term_s1 [MAX_MOTIF_LEN];
	logic signed [MASK_W-1:0]      mask_term_s1 [MAX_MOTIF_LEN];
	logic [MAX_MOTIF_LEN-1:0]      fwd_inf_s1;
	logic [MAX_MOTIF_LEN-1:0]      rev_inf_s1;
	logic [MAX_MOTIF_LEN-1:0]      mask_inf_s1;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motif_length   <= LEN_RESET;
			cfg_q.revcomp_enable <= 1'b0;
			cfg_q.viterbi_mode   <= 1'b0;
			cfg_q.mask_enable    <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MOTIF_LENGTH:   cfg_q.motif_length   <= cfg.data[LEN_W-1:0];
				REG_REVCOMP_ENABLE: cfg_q.revcomp_enable <= cfg.data[0];
				REG_VITERBI_MODE:   cfg_q.viterbi_mode   <= cfg.data[0];
				REG_MASK_ENABLE:    cfg_q.mask_enable    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// zero length acts as one, long lengths clip to the window depth
	always_comb begin
		if (cfg_q.motif_length == '0) begin
			len_c = CNT_W'(1);
		end else if (32'(cfg_q.motif_length) > MAX_MOTIF_LEN) begin
			len_c = CNT_W'(MAX_MOTIF_LEN);
		end else begin
			len_c = CNT_W'(cfg_q.motif_length);
		end
	end

	assign rdy_s1       = !ctl_s1.valid || rdy_s2;
	assign seq_in.ready = rdy_s1;
	assign base_acc     = seq_in.valid && seq_in.ready && (seq_in.func == FUNC_BASE);
	assign wr_acc       = seq_in.valid && seq_in.ready && (seq_in.func == FUNC_WEIGHT);

	// fill count after this base
	always_comb begin
		fill_b = seq_in.first_of_sequence ? '0 : fill_q;
		fill_n = (32'(fill_b) < MAX_MOTIF_LEN) ? fill_b + CNT_W'(1) : fill_b;
		sv_c   = (fill_n >= len_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (base_acc) begin
			fill_q <= fill_n;
		end
	end

	// history with the new base shifted in, newest at index 0
	always_comb begin
		hist_n[0] = seq_in.base;
		mask_n[0] = seq_in.mask_score;
		for (int k = 1; k < MAX_MOTIF_LEN; k++) begin
			hist_n[k] = hist_q[k-1];
			mask_n[k] = mask_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (base_acc) begin
			hist_q <= hist_n;
			mask_q <= mask_n;
		end
	end

	// oldest-first view of the window: forward position i reads base len-1-i
	always_comb begin
		for (int k = 0; k < MAX_MOTIF_LEN; k++) begin
			rv_c[BASE_W*k +: BASE_W] = hist_n[MAX_MOTIF_LEN-1-k];
		end
		shamt_c = SH_W'(BASE_W * (MAX_MOTIF_LEN - int'(len_c)));
		sh_c    = rv_c >> shamt_c;
	end

	for (genvar p = 0; p < MAX_MOTIF_LEN; p++) begin : g_pos
		dmws_pos_cell #(
			.WEIGHT_BITS(WEIGHT_BITS)
		) u_cell (
			.clk         (clk),
			.wr_en       (wr_acc && (32'(seq_in.motif_position) == p)),
			.wr_base     (seq_in.base),
			.wr_data     (seq_in.weight_value),
			.ld_s1       (base_acc),
			.fwd_base    (sh_c[BASE_W*p +: BASE_W]),
			.rev_base    (hist_n[p]),
			.fwd_use     (32'(len_c) > p),
			.rev_use     (cfg_q.revcomp_enable && (32'(len_c) > p)),
			.fwd_term_s1 (fwd_term_s1[p]),
			.fwd_inf_s1  (fwd_inf_s1[p]),
			.rev_term_s1 (rev_term_s1[p]),
			.rev_inf_s1  (rev_inf_s1[p])
		);
	end

	// mask terms of the window, zero outside it or with masking off
	always_ff @(posedge clk) begin
		if (base_acc) begin
			for (int j = 0; j < MAX_MOTIF_LEN; j++) begin
				if (cfg_q.mask_enable && (32'(len_c) > j)) begin
					mask_inf_s1[j]  <= (mask_n[j] == MASK_NEG_INF);
					mask_term_s1[j] <= (mask_n[j] == MASK_NEG_INF) ? '0 : mask_n[j];
				end else begin
					mask_inf_s1[j]  <= 1'b0;
					mask_term_s1[j] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (rdy_s1) begin
			ctl_s1.valid       <= base_acc;
			ctl_s1.score_valid <= sv_c;
		end
	end

	dmws_sum #(
		.MAX_MOTIF_LEN(MAX_MOTIF_LEN),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_sum (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_q        (cfg_q),
		.ctl_s1       (ctl_s1),
		.fwd_term_s1  (fwd_term_s1),
		.rev_term_s1  (rev_term_s1),
		.mask_term_s1 (mask_term_s1),
		.fwd_inf_s1   (fwd_inf_s1),
		.rev_inf_s1   (rev_inf_s1),
		.mask_inf_s1  (mask_inf_s1),
		.rdy_s2       (rdy_s2),
		.score_out    (score_out)
	);

	`DMWS_ASSERT_NEXT(a_base_enters_s1, clk, arst_n, base_acc, ctl_s1.valid, "accepted base missing from stage one")
	`DMWS_ASSERT_NEXT(a_first_restarts, clk, arst_n, base_acc && seq_in.first_of_sequence, fill_q == CNT_W'(1), "first base did not restart the fill")
	`DMWS_ASSERT_NOW(a_stall_only_full, clk, arst_n, !seq_in.ready, ctl_s1.valid, "input stalled with stage one empty")

endmodule
